// ===== rtl/dual_envelope_transient_tracker_unit_defines.svh =====
// Assertion macros used by the tracker's back part.
`ifndef DUAL_ENVELOPE_TRANSIENT_TRACKER_UNIT_DEFINES_SVH
`define DUAL_ENVELOPE_TRANSIENT_TRACKER_UNIT_DEFINES_SVH

// The condition must make the expression hold in the same cycle.
`define DETT_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition must make the expression hold in the next cycle.
`define DETT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/dett_pkg.sv =====
// Shared types, constants and fixed-point helpers of the envelope tracker.
package dett_pkg;

    // Envelope, activity and brightness fixed point: E fraction bits, 1.0 = 2^E.
    localparam int ENV_FRAC_BITS = 24;
    localparam int ENV_W         = ENV_FRAC_BITS + 1;
    localparam int Q15_SHIFT     = ENV_FRAC_BITS - 15;
    localparam int COEF_W        = 24;
    localparam int SAMPLE_W      = 16;
    localparam int Q15_W         = 16;
    localparam int DETAIL_W      = 29;
    localparam int MAG_W         = 28;
    localparam int ACT_W         = 23;
    localparam int NUM_W         = 40;
    localparam int DEN_W         = 41;
    localparam int QUO_BITS      = 24;
    localparam int CNT_W         = 5;
    localparam int CFG_ADDR_W    = 3;
    localparam int REC_DEPTH     = 2;

    localparam logic [ENV_W-1:0]    ENV_ONE     = ENV_W'(1) << ENV_FRAC_BITS;
    localparam logic [Q15_W-1:0]    Q15_ONE     = 16'h8000;
    localparam logic [DETAIL_W-1:0] DETAIL_MAX  = '1;
    localparam logic [MAG_W-1:0]    MAG_MAX     = '1;
    localparam logic [Q15_W-1:0]    ACT_FLOOR   = 16'd26;
    localparam logic [ACT_W-1:0]    ACT_CAP     = 23'd5872026;
    localparam logic [COEF_W-1:0]   PRODUCT_ONE = 24'hFFFFFF;
    localparam logic [7:0]          EPS_256     = 8'd84;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_ATTACK   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_RELEASE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_ATTACK   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_RELEASE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVITY_DECAY = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHT_DECAY  = 3'd5;

    // Coefficient reset values.
    localparam logic [COEF_W-1:0] RST_FAST_ATTACK    = 24'd231400;
    localparam logic [COEF_W-1:0] RST_FAST_RELEASE   = 24'd19406;
    localparam logic [COEF_W-1:0] RST_SLOW_ATTACK    = 24'd17467;
    localparam logic [COEF_W-1:0] RST_SLOW_RELEASE   = 24'd2496;
    localparam logic [COEF_W-1:0] RST_ACTIVITY_DECAY = 24'd16771392;
    localparam logic [COEF_W-1:0] RST_BRIGHT_DECAY   = 24'd16769451;

    typedef struct packed {
        logic [COEF_W-1:0] fast_attack;
        logic [COEF_W-1:0] fast_release;
        logic [COEF_W-1:0] slow_attack;
        logic [COEF_W-1:0] slow_release;
        logic [COEF_W-1:0] activity_decay;
        logic [COEF_W-1:0] bright_decay;
    } t_coeffs;

    // One closed block, handed from the front part to the back part.
    typedef struct packed {
        logic [Q15_W-1:0]    one_env;
        logic [Q15_W-1:0]    two_env;
        logic [Q15_W-1:0]    transient;
        logic [Q15_W-1:0]    activity;
        logic [DETAIL_W-1:0] detail;
        logic [MAG_W-1:0]    magnitude;
        logic [COEF_W-1:0]   product;
    } t_block_rec;

    typedef struct packed {
        logic [Q15_W-1:0] one_env;
        logic [Q15_W-1:0] two_env;
        logic [Q15_W-1:0] transient;
        logic [Q15_W-1:0] activity;
        logic [Q15_W-1:0] brightness;
    } t_result;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_CHECK,
        B_DIV,
        B_DIFF,
        B_MUL,
        B_UPDATE,
        B_EMIT
    } t_back_state;

    // Multiply by a Q0.24 fraction, rounding half up.
    function automatic logic [ENV_W-1:0] mul_q24(input logic [ENV_W-1:0] x,
                                                 input logic [COEF_W-1:0] c);
        logic [ENV_W+COEF_W-1:0] p;
        p = (ENV_W+COEF_W)'(x) * (ENV_W+COEF_W)'(c)
            + ((ENV_W+COEF_W)'(1) << (COEF_W - 1));
        return p[ENV_W+COEF_W-1:COEF_W];
    endfunction

    // Convert to Q1.15 with rounding half up, saturated at 1.0.
    function automatic logic [Q15_W-1:0] to_q15(input logic [ENV_W-1:0] x);
        logic [ENV_W:0]    sum;
        logic [ENV_W-Q15_SHIFT:0] r;
        sum = (ENV_W+1)'(x) + ((ENV_W+1)'(1) << (Q15_SHIFT - 1));
        r   = sum[ENV_W:Q15_SHIFT];
        if (r > (ENV_W-Q15_SHIFT+1)'(Q15_ONE)) begin
            return Q15_ONE;
        end
        return r[Q15_W-1:0];
    endfunction

    // One attack/release follower step.
    function automatic logic [ENV_W-1:0] follow(input logic [ENV_W-1:0] env,
                                                input logic [ENV_W-1:0] tgt,
                                                input logic [COEF_W-1:0] rise,
                                                input logic [COEF_W-1:0] fall);
        if (tgt > env) begin
            return env + mul_q24(tgt - env, rise);
        end
        return env - mul_q24(env - tgt, fall);
    endfunction

endpackage

// ===== rtl/dual_envelope_transient_tracker_unit.sv =====
// Top level of the dual envelope transient tracker.
//
//  Channel  | Direction | Handshake                  | Word
//  ---------+-----------+----------------------------+------------------------------------
//  samples  | in        | push, full                 | two Q1.15 samples, last_of_block
//  results  | out       | empty, pop                 | five Q1.15 block values
//  config   | in        | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_data (24 bits)
//
// The front part takes one sample word per cycle while the record queue has room; after a
// word marked last_of_block it takes none in the next cycle while the block is closed and queued.
// The back part takes a new record only once it has emitted the last one, and spends most
// of its work in a 24-step restoring divider; a two-entry record queue lets short blocks pile up,
// and full stays high while the queue is full.
// Reset is synchronous and active low; all control state starts at once, with no clearing pass.
// A result waits in the output register until popped while the front keeps working.
module dual_envelope_transient_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [15:0]                  i_channel_one_sample,
    input  logic signed [15:0]                  i_channel_two_sample,
    input  logic                                i_last_of_block,
    output logic                                empty,
    input  logic                                pop,
    output logic [15:0]                         o_one_envelope,
    output logic [15:0]                         o_two_envelope,
    output logic [15:0]                         o_block_transient,
    output logic [15:0]                         o_block_activity,
    output logic [15:0]                         o_tone_brightness,
    input  logic                                i_cfg_we,
    input  logic [dett_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dett_pkg::COEF_W-1:0]         i_cfg_data
);

    dett_pkg::t_coeffs    r_coeffs, n_coeffs;
    dett_pkg::t_block_rec front_rec;
    dett_pkg::t_block_rec queue_rec;
    dett_pkg::t_result    result;
    logic                 front_busy;
    logic                 rec_push;
    logic                 rec_pop;
    logic                 rec_empty;
    logic                 rec_full;
    logic                 accept;

    // Coefficient register writes; unknown indexes are ignored.
    always_comb begin
        n_coeffs = r_coeffs;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                dett_pkg::CFG_FAST_ATTACK:    n_coeffs.fast_attack    = i_cfg_data;
                dett_pkg::CFG_FAST_RELEASE:   n_coeffs.fast_release   = i_cfg_data;
                dett_pkg::CFG_SLOW_ATTACK:    n_coeffs.slow_attack    = i_cfg_data;
                dett_pkg::CFG_SLOW_RELEASE:   n_coeffs.slow_release   = i_cfg_data;
                dett_pkg::CFG_ACTIVITY_DECAY: n_coeffs.activity_decay = i_cfg_data;
                dett_pkg::CFG_BRIGHT_DECAY:   n_coeffs.bright_decay   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs.fast_attack    <= dett_pkg::RST_FAST_ATTACK;
            r_coeffs.fast_release   <= dett_pkg::RST_FAST_RELEASE;
            r_coeffs.slow_attack    <= dett_pkg::RST_SLOW_ATTACK;
            r_coeffs.slow_release   <= dett_pkg::RST_SLOW_RELEASE;
            r_coeffs.activity_decay <= dett_pkg::RST_ACTIVITY_DECAY;
            r_coeffs.bright_decay   <= dett_pkg::RST_BRIGHT_DECAY;
        end else begin
            r_coeffs <= n_coeffs;
        end
    end

    // Input acceptance: blocked during a close and while the record queue is full.
    assign full   = front_busy || rec_full;
    assign accept = push && !full;

    dett_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_coeffs             (r_coeffs),
        .i_accept             (accept),
        .i_channel_one_sample (i_channel_one_sample),
        .i_channel_two_sample (i_channel_two_sample),
        .i_last_of_block      (i_last_of_block),
        .o_busy               (front_busy),
        .o_rec_push           (rec_push),
        .o_rec                (front_rec)
    );

    dett_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (front_rec),
        .i_pop   (rec_pop),
        .o_data  (queue_rec),
        .o_empty (rec_empty),
        .o_full  (rec_full)
    );

    dett_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (rec_empty),
        .i_rec       (queue_rec),
        .o_rec_pop   (rec_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_one_envelope    = result.one_env;
    assign o_two_envelope    = result.two_env;
    assign o_block_transient = result.transient;
    assign o_block_activity  = result.activity;
    assign o_tone_brightness = result.brightness;

endmodule

// ===== rtl/dett_front.sv =====
// Front part: per-word envelope followers, block accumulators and block close.
module dett_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dett_pkg::t_coeffs           i_coeffs,
    input  logic                        i_accept,
    input  logic signed [15:0]          i_channel_one_sample,
    input  logic signed [15:0]          i_channel_two_sample,
    input  logic                        i_last_of_block,
    output logic                        o_busy,
    output logic                        o_rec_push,
    output dett_pkg::t_block_rec        o_rec
);

    localparam int ENV_W = dett_pkg::ENV_W;

    logic [ENV_W-1:0]              r_fast [2];
    logic [ENV_W-1:0]              r_slow [2];
    logic [ENV_W-1:0]              n_fast [2];
    logic [ENV_W-1:0]              n_slow [2];
    logic signed [15:0]            r_prior, n_prior;
    logic [dett_pkg::DETAIL_W-1:0] r_detail, n_detail;
    logic [dett_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic [15:0]                   r_peak, n_peak;
    logic [dett_pkg::ACT_W-1:0]    r_act, n_act;
    logic [dett_pkg::COEF_W-1:0]   r_prod, n_prod;
    logic                          r_b_valid, n_b_valid;
    logic                          r_b_last, n_b_last;

    logic [15:0]                   mag [2];
    logic signed [16:0]            step;
    logic [16:0]                   step_neg;
    logic [15:0]                   step_abs;
    logic [dett_pkg::DETAIL_W:0]   detail_sum;
    logic [dett_pkg::MAG_W:0]      mag_sum;
    logic [15:0]                   trans_now;
    logic [15:0]                   peak_new;
    logic [15:0]                   over;
    logic [20:0]                   scaled;
    logic [29:0]                   shifted;
    logic [dett_pkg::ACT_W-1:0]    capped;
    logic [dett_pkg::ACT_W-1:0]    act_close;

    // Magnitude of a signed sample; the most negative one maps to 1.0.
    function automatic logic [15:0] abs16(input logic signed [15:0] s);
        logic [15:0] neg;
        neg = ~s + 16'd1;
        return s[15] ? neg : s;
    endfunction

    // Stage A: followers, accumulators and per-word decays.
    always_comb begin
        mag[0] = abs16(i_channel_one_sample);
        mag[1] = abs16(i_channel_two_sample);
        for (int ch = 0; ch < 2; ch++) begin
            n_fast[ch] = dett_pkg::follow(r_fast[ch],
                                          ENV_W'(mag[ch]) << dett_pkg::Q15_SHIFT,
                                          i_coeffs.fast_attack, i_coeffs.fast_release);
            n_slow[ch] = dett_pkg::follow(r_slow[ch],
                                          ENV_W'(mag[ch]) << dett_pkg::Q15_SHIFT,
                                          i_coeffs.slow_attack, i_coeffs.slow_release);
        end
        step     = {i_channel_two_sample[15], i_channel_two_sample}
                   - {r_prior[15], r_prior};
        step_neg = 17'(-step);
        step_abs = step[16] ? step_neg[15:0] : step[15:0];
        detail_sum = (dett_pkg::DETAIL_W+1)'(r_detail) + (dett_pkg::DETAIL_W+1)'(step_abs);
        mag_sum    = (dett_pkg::MAG_W+1)'(r_mag) + (dett_pkg::MAG_W+1)'(mag[1]);
    end

    // Stage B: transient peak from the updated envelopes, and the block close.
    always_comb begin
        trans_now = '0;
        if (r_fast[1] > r_slow[1]) begin
            trans_now = dett_pkg::to_q15(r_fast[1] - r_slow[1]);
        end
        peak_new = (trans_now > r_peak) ? trans_now : r_peak;
        over     = (peak_new > dett_pkg::ACT_FLOOR) ? peak_new - dett_pkg::ACT_FLOOR : '0;
        scaled   = (21'(over) << 4) + (21'(over) << 3);
        shifted  = 30'(scaled) << dett_pkg::Q15_SHIFT;
        capped   = (shifted > 30'(dett_pkg::ACT_CAP)) ? dett_pkg::ACT_CAP
                                                      : shifted[dett_pkg::ACT_W-1:0];
        act_close = (capped > r_act) ? capped : r_act;
    end

    // Next-state selection for both stages.
    always_comb begin
        n_prior   = r_prior;
        n_detail  = r_detail;
        n_mag     = r_mag;
        n_peak    = r_peak;
        n_act     = r_act;
        n_prod    = r_prod;
        n_b_valid = i_accept;
        n_b_last  = i_accept && i_last_of_block;
        if (i_accept) begin
            n_prior  = i_channel_two_sample;
            n_detail = (detail_sum > (dett_pkg::DETAIL_W+1)'(dett_pkg::DETAIL_MAX))
                       ? dett_pkg::DETAIL_MAX : detail_sum[dett_pkg::DETAIL_W-1:0];
            n_mag    = (mag_sum > (dett_pkg::MAG_W+1)'(dett_pkg::MAG_MAX))
                       ? dett_pkg::MAG_MAX : mag_sum[dett_pkg::MAG_W-1:0];
            n_act    = dett_pkg::ACT_W'(dett_pkg::mul_q24(ENV_W'(r_act),
                                                          i_coeffs.activity_decay));
            n_prod   = dett_pkg::COEF_W'(dett_pkg::mul_q24(ENV_W'(r_prod),
                                                           i_coeffs.bright_decay));
        end
        if (r_b_valid) begin
            n_peak = peak_new;
        end
        // No word is taken while a close is in stage B, so these cannot collide.
        if (r_b_valid && r_b_last) begin
            n_peak   = '0;
            n_act    = act_close;
            n_detail = '0;
            n_mag    = '0;
            n_prod   = dett_pkg::PRODUCT_ONE;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_fast[ch] <= '0;
                r_slow[ch] <= '0;
            end
            r_prior   <= '0;
            r_detail  <= '0;
            r_mag     <= '0;
            r_peak    <= '0;
            r_act     <= '0;
            r_prod    <= dett_pkg::PRODUCT_ONE;
            r_b_valid <= 1'b0;
            r_b_last  <= 1'b0;
        end else begin
            if (i_accept) begin
                for (int ch = 0; ch < 2; ch++) begin
                    r_fast[ch] <= n_fast[ch];
                    r_slow[ch] <= n_slow[ch];
                end
            end
            r_prior   <= n_prior;
            r_detail  <= n_detail;
            r_mag     <= n_mag;
            r_peak    <= n_peak;
            r_act     <= n_act;
            r_prod    <= n_prod;
            r_b_valid <= n_b_valid;
            r_b_last  <= n_b_last;
        end
    end

    // The closed block as a record for the back part.
    assign o_busy     = r_b_valid && r_b_last;
    assign o_rec_push = r_b_valid && r_b_last;
    always_comb begin
        o_rec.one_env   = dett_pkg::to_q15(r_slow[0]);
        o_rec.two_env   = dett_pkg::to_q15(r_slow[1]);
        o_rec.transient = peak_new;
        o_rec.activity  = dett_pkg::to_q15(ENV_W'(act_close));
        o_rec.detail    = r_detail;
        o_rec.magnitude = r_mag;
        o_rec.product   = r_prod;
    end

endmodule

// ===== rtl/dett_queue.sv =====
// Short queue of closed-block records between the front and back parts.
module dett_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dett_pkg::t_block_rec i_data,
    input  logic                 i_pop,
    output dett_pkg::t_block_rec o_data,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int DEPTH = dett_pkg::REC_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dett_pkg::t_block_rec r_slots [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slots[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/dett_back.sv =====
// Back part: brightness target division, smoothing and the result register.
`include "dual_envelope_transient_tracker_unit_defines.svh"

module dett_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rec_empty,
    input  dett_pkg::t_block_rec i_rec,
    output logic                 o_rec_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output dett_pkg::t_result    o_result
);

    localparam int ENV_W = dett_pkg::ENV_W;
    localparam int NUM_W = dett_pkg::NUM_W;
    localparam int DEN_W = dett_pkg::DEN_W;
    localparam int CNT_W = dett_pkg::CNT_W;
    localparam int QB    = dett_pkg::QUO_BITS;

    dett_pkg::t_back_state  r_state, n_state;
    dett_pkg::t_block_rec   r_rec, n_rec;
    logic [DEN_W-1:0]       r_rem, n_rem;
    logic [DEN_W-1:0]       r_den, n_den;
    logic [QB-1:0]          r_quo, n_quo;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ENV_W-1:0]       r_target, n_target;
    logic                   r_ge, n_ge;
    logic [ENV_W-1:0]       r_diff, n_diff;
    logic [ENV_W-1:0]       r_m, n_m;
    logic [ENV_W-1:0]       r_bright, n_bright;
    logic                   r_out_valid, n_out_valid;
    dett_pkg::t_result      r_out, n_out;

    logic [NUM_W-1:0]       num;
    logic [35:0]            den_base;
    logic [DEN_W-1:0]       den;
    logic [DEN_W:0]         rem_shift;
    logic [DEN_W:0]         rem_sub;
    logic                   quo_bit;
    logic [QB-1:0]          quo_next;

    // Numerator and denominator of 0.35 * detail / (magnitude + eps), scaled by 20 * 256.
    always_comb begin
        num = (NUM_W'(r_rec.detail) << 10) + (NUM_W'(r_rec.detail) << 9)
              + (NUM_W'(r_rec.detail) << 8);
        den_base = (36'(r_rec.magnitude) << 8) + 36'(dett_pkg::EPS_256);
        den = (DEN_W'(den_base) << 4) + (DEN_W'(den_base) << 2);
    end

    // One restoring division step.
    always_comb begin
        rem_shift = {r_rem, 1'b0};
        rem_sub   = rem_shift - {1'b0, r_den};
        quo_bit   = (rem_shift >= {1'b0, r_den});
        quo_next  = {r_quo[QB-2:0], quo_bit};
    end

    // Sequencer: next state and datapath selection.
    always_comb begin
        n_state     = r_state;
        n_rec       = r_rec;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_count     = r_count;
        n_target    = r_target;
        n_ge        = r_ge;
        n_diff      = r_diff;
        n_m         = r_m;
        n_bright    = r_bright;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_rec_pop   = 1'b0;
        case (r_state)
            dett_pkg::B_IDLE: begin
                if (!i_rec_empty) begin
                    o_rec_pop = 1'b1;
                    n_rec     = i_rec;
                    n_state   = dett_pkg::B_LOAD;
                end
            end
            dett_pkg::B_LOAD: begin
                n_rem   = DEN_W'(num);
                n_den   = den;
                n_state = dett_pkg::B_CHECK;
            end
            dett_pkg::B_CHECK: begin
                // A ratio of one or more saturates the target at 1.0.
                if (r_rem >= r_den) begin
                    n_target = dett_pkg::ENV_ONE;
                    n_state  = dett_pkg::B_DIFF;
                end else begin
                    n_quo   = '0;
                    n_count = '0;
                    n_state = dett_pkg::B_DIV;
                end
            end
            dett_pkg::B_DIV: begin
                n_rem   = quo_bit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                n_quo   = quo_next;
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(QB - 1)) begin
                    n_target = ENV_W'(quo_next);
                    n_state  = dett_pkg::B_DIFF;
                end
            end
            dett_pkg::B_DIFF: begin
                n_ge    = (r_bright >= r_target);
                n_diff  = (r_bright >= r_target) ? r_bright - r_target : r_target - r_bright;
                n_state = dett_pkg::B_MUL;
            end
            dett_pkg::B_MUL: begin
                n_m     = dett_pkg::mul_q24(r_diff, r_rec.product);
                n_state = dett_pkg::B_UPDATE;
            end
            dett_pkg::B_UPDATE: begin
                n_bright = r_ge ? r_target + r_m : r_target - r_m;
                n_state  = dett_pkg::B_EMIT;
            end
            dett_pkg::B_EMIT: begin
                // Wait here until the result register is free or being emptied.
                if (!r_out_valid || i_pop) begin
                    n_out.one_env    = r_rec.one_env;
                    n_out.two_env    = r_rec.two_env;
                    n_out.transient  = r_rec.transient;
                    n_out.activity   = r_rec.activity;
                    n_out.brightness = dett_pkg::to_q15(r_bright);
                    n_out_valid      = 1'b1;
                    n_state          = dett_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = dett_pkg::B_IDLE;
            end
        endcase
    end

    // State register and brightness state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dett_pkg::B_IDLE;
            r_bright    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bright    <= n_bright;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rec    <= n_rec;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quo    <= n_quo;
        r_count  <= n_count;
        r_target <= n_target;
        r_ge     <= n_ge;
        r_diff   <= n_diff;
        r_m      <= n_m;
        r_out    <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // The partial remainder stays below the divisor in every division step.
    `DETT_ASSERT_IMPLY(a_div_rem_below_den, i_clk, i_rst_n, r_state == dett_pkg::B_DIV, r_rem < r_den, "division remainder reached the divisor")
    // The brightness target and state never pass 1.0.
    `DETT_ASSERT_IMPLY(a_target_in_range, i_clk, i_rst_n, r_state == dett_pkg::B_DIFF, r_target <= dett_pkg::ENV_ONE, "brightness target above 1.0")
    `DETT_ASSERT_IMPLY(a_bright_in_range, i_clk, i_rst_n, 1'b1, r_bright <= dett_pkg::ENV_ONE, "brightness state above 1.0")
    // A waiting result is not overwritten: the sequencer holds in its emit state.
    `DETT_ASSERT_NEXT(a_emit_holds, i_clk, i_rst_n, (r_state == dett_pkg::B_EMIT) && r_out_valid && !i_pop, r_state == dett_pkg::B_EMIT, "result register overwritten while full")

endmodule

// ===== bench/dett_tracker_check.sv =====
// Result checker for the envelope tracker: mirrors its state and compares every result word.
module dett_tracker_check
    import dett_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic signed [15:0]    i_channel_one_sample,
    input  logic signed [15:0]    i_channel_two_sample,
    input  logic                  i_last_of_block,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [15:0]           i_one_envelope,
    input  logic [15:0]           i_two_envelope,
    input  logic [15:0]           i_block_transient,
    input  logic [15:0]           i_block_activity,
    input  logic [15:0]           i_tone_brightness,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COEF_W-1:0]     i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    // Levels carry 24 fraction bits, so 1.0 needs a 25th bit.
    typedef logic [24:0] t_level;

    localparam int          LEVEL_SHIFT    = 9;
    localparam t_level      LEVEL_ONE      = 25'd1 << 24;
    localparam logic [28:0] DETAIL_LIMIT   = '1;
    localparam logic [27:0] MAG_LIMIT      = '1;
    localparam logic [15:0] ACTIVITY_FLOOR = 16'd26;
    localparam logic [63:0] ACTIVITY_GAIN  = 64'd24;
    localparam logic [63:0] ACTIVITY_CAP   = ((64'd7 << 24) + 64'd10) / 64'd20;
    // Brightness target is 0.35 * detail / (magnitude + eps), eps in 1/256 sample steps.
    localparam logic [63:0] RATIO_NUM      = 64'd7 * 64'd256;
    localparam logic [63:0] RATIO_DEN      = 64'd20;
    localparam logic [63:0] EPS_STEPS      = 64'd84;
    localparam logic [23:0] PRODUCT_FULL   = 24'hFFFFFF;
    localparam int          PRINT_LIMIT    = 40;

    t_coeffs       coeffs;
    t_level        fast_level [2];
    t_level        slow_level [2];
    logic signed [15:0] last_two;
    logic [28:0]   detail_acc;
    logic [27:0]   mag_acc;
    logic [15:0]   peak_q15;
    t_level        activity_lvl;
    t_level        brightness_lvl;
    logic [23:0]   retain_product;
    t_result       expected_q [$];
    t_result       seen;
    t_result       wanted;
    int            mismatch_total = 0;

    // Multiply by an unsigned Q0.24 fraction, rounding half up.
    function automatic t_level scale_frac(input t_level x, input logic [23:0] c);
        logic [63:0] p;
        p = 64'(x) * 64'(c) + 64'h80_0000;
        return t_level'(p >> 24);
    endfunction

    // Round a level to Q1.15 and saturate at 1.0.
    function automatic logic [15:0] level_to_q15(input t_level x);
        logic [31:0] r;
        r = (32'(x) + 32'd256) >> LEVEL_SHIFT;
        return (r > 32'd32768) ? 16'h8000 : r[15:0];
    endfunction

    function automatic t_level follow_step(input t_level lvl, input t_level tgt,
                                           input logic [23:0] rise, input logic [23:0] fall);
        if (tgt > lvl) begin
            return lvl + scale_frac(tgt - lvl, rise);
        end
        return lvl - scale_frac(lvl - tgt, fall);
    endfunction

    function automatic logic [16:0] abs_value(input logic signed [16:0] v);
        return (v < 0) ? 17'(-v) : 17'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_total < PRINT_LIMIT) begin
            $display("[%0t] tracker mismatch: %s", $time, msg);
        end
        mismatch_total++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
        end
    endtask

    // Advance the mirrored state by one sample word; a closing word queues its result.
    task automatic track_sample(input logic signed [15:0] one, input logic signed [15:0] two,
                                input logic closes_block);
        t_level             in_level [2];
        logic signed [16:0] delta;
        logic [31:0]        total;
        logic [15:0]        rise_q15;
        logic [63:0]        boost;
        logic [63:0]        numer;
        logic [63:0]        denom;
        logic [127:0]       ratio;
        t_level             target;
        t_result            res;
        int                 ch;

        in_level[0] = t_level'(abs_value(17'(one))) << LEVEL_SHIFT;
        in_level[1] = t_level'(abs_value(17'(two))) << LEVEL_SHIFT;
        for (ch = 0; ch < 2; ch++) begin
            fast_level[ch] = follow_step(fast_level[ch], in_level[ch],
                                         coeffs.fast_attack, coeffs.fast_release);
            slow_level[ch] = follow_step(slow_level[ch], in_level[ch],
                                         coeffs.slow_attack, coeffs.slow_release);
        end

        // Channel two feeds the saturating detail and magnitude sums.
        delta = 17'(two) - 17'(last_two);
        total = 32'(detail_acc) + 32'(abs_value(delta));
        detail_acc = (total > 32'(DETAIL_LIMIT)) ? DETAIL_LIMIT : total[28:0];
        total = 32'(mag_acc) + 32'(abs_value(17'(two)));
        mag_acc = (total > 32'(MAG_LIMIT)) ? MAG_LIMIT : total[27:0];
        last_two = two;

        if (fast_level[1] > slow_level[1]) begin
            rise_q15 = level_to_q15(fast_level[1] - slow_level[1]);
            if (rise_q15 > peak_q15) begin
                peak_q15 = rise_q15;
            end
        end

        activity_lvl = scale_frac(activity_lvl, coeffs.activity_decay);
        retain_product = 24'(scale_frac(t_level'(retain_product), coeffs.bright_decay));

        if (!closes_block) begin
            return;
        end

        // Activity is raised to the capped, scaled transient above the floor.
        boost = (peak_q15 > ACTIVITY_FLOOR) ?
                64'(peak_q15 - ACTIVITY_FLOOR) * ACTIVITY_GAIN : 64'd0;
        boost = boost << LEVEL_SHIFT;
        if (boost > ACTIVITY_CAP) begin
            boost = ACTIVITY_CAP;
        end
        if (boost > 64'(activity_lvl)) begin
            activity_lvl = t_level'(boost);
        end

        // Brightness moves toward the clamped detail-to-magnitude ratio.
        numer = 64'(detail_acc) * RATIO_NUM;
        denom = RATIO_DEN * (64'(mag_acc) * 64'd256 + EPS_STEPS);
        if (numer >= denom) begin
            target = LEVEL_ONE;
        end else begin
            ratio = (128'(numer) << 24) / 128'(denom);
            target = t_level'(ratio);
        end
        if (brightness_lvl >= target) begin
            brightness_lvl = target + scale_frac(brightness_lvl - target, retain_product);
        end else begin
            brightness_lvl = target - scale_frac(target - brightness_lvl, retain_product);
        end

        res.one_env    = level_to_q15(slow_level[0]);
        res.two_env    = level_to_q15(slow_level[1]);
        res.transient  = (peak_q15 > 16'h8000) ? 16'h8000 : peak_q15;
        res.activity   = level_to_q15(activity_lvl);
        res.brightness = level_to_q15(brightness_lvl);
        expected_q.push_back(res);

        detail_acc     = '0;
        mag_acc        = '0;
        peak_q15       = '0;
        retain_product = PRODUCT_FULL;
    endtask

    // All channels are sampled at the rising edge, before anything driven at that edge lands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coeffs.fast_attack    = RST_FAST_ATTACK;
            coeffs.fast_release   = RST_FAST_RELEASE;
            coeffs.slow_attack    = RST_SLOW_ATTACK;
            coeffs.slow_release   = RST_SLOW_RELEASE;
            coeffs.activity_decay = RST_ACTIVITY_DECAY;
            coeffs.bright_decay   = RST_BRIGHT_DECAY;
            fast_level[0]  = '0;
            fast_level[1]  = '0;
            slow_level[0]  = '0;
            slow_level[1]  = '0;
            last_two       = '0;
            detail_acc     = '0;
            mag_acc        = '0;
            peak_q15       = '0;
            activity_lvl   = '0;
            brightness_lvl = '0;
            retain_product = PRODUCT_FULL;
            expected_q.delete();
        end else begin
            // Writes to indexes outside the register list are dropped.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FAST_ATTACK:    coeffs.fast_attack    = i_cfg_data;
                    CFG_FAST_RELEASE:   coeffs.fast_release   = i_cfg_data;
                    CFG_SLOW_ATTACK:    coeffs.slow_attack    = i_cfg_data;
                    CFG_SLOW_RELEASE:   coeffs.slow_release   = i_cfg_data;
                    CFG_ACTIVITY_DECAY: coeffs.activity_decay = i_cfg_data;
                    CFG_BRIGHT_DECAY:   coeffs.bright_decay   = i_cfg_data;
                    default: ;
                endcase
            end

            // A popped result word is compared with the oldest expected one.
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word popped with no expected result waiting");
                end else begin
                    wanted = expected_q.pop_front();
                    seen.one_env    = i_one_envelope;
                    seen.two_env    = i_two_envelope;
                    seen.transient  = i_block_transient;
                    seen.activity   = i_block_activity;
                    seen.brightness = i_tone_brightness;
                    check_field("one_envelope", seen.one_env, wanted.one_env);
                    check_field("two_envelope", seen.two_env, wanted.two_env);
                    check_field("block_transient", seen.transient, wanted.transient);
                    check_field("block_activity", seen.activity, wanted.activity);
                    check_field("tone_brightness", seen.brightness, wanted.brightness);
                end
            end

            if (i_push && !i_full) begin
                track_sample(i_channel_one_sample, i_channel_two_sample, i_last_of_block);
            end
        end
        o_outstanding <= expected_q.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the envelope tracker bench: clock, reset, sample and result traffic, and the verdict.
module tb_top;
    import dett_pkg::*;

    typedef enum int {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    typedef enum int {
        SET_RESET,
        SET_MAX,
        SET_ZERO,
        SET_RANDOM,
        SET_GENTLE,
        SET_SKEWED
    } t_coeff_set;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_QUIET,
        SHAPE_BURST,
        SHAPE_STEADY,
        SHAPE_EXTREME
    } t_shape;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 200;
    localparam int LONG_BLOCK_LEN = 96;
    localparam int HEAVY_PCT      = 82;
    localparam int LIGHT_PCT      = 16;

    // Register indexes past the end of the list; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  push       = 1'b0;
    logic                  full;
    logic signed [15:0]    one_sample = '0;
    logic signed [15:0]    two_sample = '0;
    logic                  last_flag  = 1'b0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [15:0]           one_env;
    logic [15:0]           two_env;
    logic [15:0]           transient;
    logic [15:0]           activity;
    logic [15:0]           brightness;
    logic                  cfg_we     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [COEF_W-1:0]     cfg_data   = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #4 clk = ~clk;

    dual_envelope_transient_tracker_unit i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .push                 (push),
        .full                 (full),
        .i_channel_one_sample (one_sample),
        .i_channel_two_sample (two_sample),
        .i_last_of_block      (last_flag),
        .empty                (empty),
        .pop                  (pop),
        .o_one_envelope       (one_env),
        .o_two_envelope       (two_env),
        .o_block_transient    (transient),
        .o_block_activity     (activity),
        .o_tone_brightness    (brightness),
        .i_cfg_we             (cfg_we),
        .i_cfg_addr           (cfg_addr),
        .i_cfg_data           (cfg_data)
    );

    dett_tracker_check u_result_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_push               (push),
        .i_full               (full),
        .i_channel_one_sample (one_sample),
        .i_channel_two_sample (two_sample),
        .i_last_of_block      (last_flag),
        .i_empty              (empty),
        .i_pop                (pop),
        .i_one_envelope       (one_env),
        .i_two_envelope       (two_env),
        .i_block_transient    (transient),
        .i_block_activity     (activity),
        .i_tone_brightness    (brightness),
        .i_cfg_we             (cfg_we),
        .i_cfg_addr           (cfg_addr),
        .i_cfg_data           (cfg_data),
        .o_mismatches         (mismatches),
        .o_outstanding        (outstanding)
    );

    // Result side: random stalls, plus a long hold-off whenever the sample side asks for one.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
            hold_left = 0;
            hold_seen = hold_seq;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD - 1;
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    // The run ends as a failure once no word moves on either side for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("dual_envelope_transient_tracker_unit regression: fail");
        $finish;
    end

    // Offer one sample word, idling first at the current rate, and return once it is taken.
    task automatic send_word(input logic signed [15:0] one, input logic signed [15:0] two,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        one_sample <= one;
        two_sample <= two;
        last_flag  <= last;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
    endtask

    // Stop offering words, wait for every expected result, then let the front part settle.
    task automatic wait_until_idle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [COEF_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic write_coeffs(input t_coeffs c);
        write_reg(CFG_FAST_ATTACK, c.fast_attack);
        write_reg(CFG_FAST_RELEASE, c.fast_release);
        write_reg(CFG_SLOW_ATTACK, c.slow_attack);
        write_reg(CFG_SLOW_RELEASE, c.slow_release);
        write_reg(CFG_ACTIVITY_DECAY, c.activity_decay);
        write_reg(CFG_BRIGHT_DECAY, c.bright_decay);
        write_reg(CFG_SPARE_LO, COEF_W'($urandom()));
        write_reg(CFG_SPARE_HI, COEF_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    function automatic t_coeffs make_coeffs(input t_coeff_set sel);
        t_coeffs c;
        case (sel)
            SET_RESET: begin
                c.fast_attack    = RST_FAST_ATTACK;
                c.fast_release   = RST_FAST_RELEASE;
                c.slow_attack    = RST_SLOW_ATTACK;
                c.slow_release   = RST_SLOW_RELEASE;
                c.activity_decay = RST_ACTIVITY_DECAY;
                c.bright_decay   = RST_BRIGHT_DECAY;
            end
            SET_MAX:  c = '1;
            SET_ZERO: c = '0;
            SET_GENTLE: begin
                // Audio-like time constants with decays just under one.
                c.fast_attack    = COEF_W'($urandom_range(1 << 16, 1 << 20));
                c.fast_release   = COEF_W'($urandom_range(1 << 12, 1 << 16));
                c.slow_attack    = COEF_W'($urandom_range(1 << 12, 1 << 16));
                c.slow_release   = COEF_W'($urandom_range(1 << 8, 1 << 13));
                c.activity_decay = COEF_W'(24'hFFFFFF - $urandom_range(0, 1 << 15));
                c.bright_decay   = COEF_W'(24'hFFFFFF - $urandom_range(0, 1 << 15));
            end
            SET_SKEWED: begin
                // A frozen slow follower lets the transient and activity hit their caps.
                c.fast_attack    = '1;
                c.fast_release   = COEF_W'($urandom());
                c.slow_attack    = '0;
                c.slow_release   = '1;
                c.activity_decay = '1;
                c.bright_decay   = COEF_W'($urandom_range(0, 1 << 12));
            end
            default: begin
                c.fast_attack    = COEF_W'($urandom());
                c.fast_release   = COEF_W'($urandom());
                c.slow_attack    = COEF_W'($urandom());
                c.slow_release   = COEF_W'($urandom());
                c.activity_decay = COEF_W'($urandom());
                c.bright_decay   = COEF_W'($urandom());
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [15:0] pick_sample(input t_shape sh, input int pos,
                                                       input int len,
                                                       input logic signed [15:0] level);
        case (sh)
            SHAPE_QUIET:  return 16'($urandom_range(0, 511)) - 16'd256;
            SHAPE_STEADY: return level;
            SHAPE_BURST: begin
                // Near silence, then a loud stretch that the fast follower jumps on.
                if (pos < len / 2) begin
                    return 16'($urandom_range(0, 31)) - 16'd16;
                end
                return $urandom_range(0, 1) ? level : -level;
            end
            SHAPE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    // Random blocks, mostly short, each closed by a word marked last of block.
    task automatic run_blocks(input int n_items);
        int                 sent;
        int                 len;
        int                 pick;
        int                 k;
        t_shape             sh;
        logic signed [15:0] level;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(1, 8);
            end else if (pick < 92) begin
                len = $urandom_range(9, 48);
            end else begin
                len = $urandom_range(49, 300);
            end
            sh    = t_shape'($urandom_range(0, 4));
            level = 16'($urandom());
            for (k = 0; k < len; k++) begin
                send_word(pick_sample(sh, k, len, level), pick_sample(sh, k, len, level),
                          k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic run_phase(input t_coeff_set sel, input t_pace pace, input int n_items,
                             input bit long_hold);
        wait_until_idle();
        write_coeffs(make_coeffs(sel));
        case (pace)
            PACE_SENDER_IDLE: begin
                send_idle_pct = HEAVY_PCT;
                pop_stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
                send_idle_pct = 0;
                pop_stall_pct = HEAVY_PCT;
            end
            PACE_BOTH: begin
                send_idle_pct = LIGHT_PCT;
                pop_stall_pct = LIGHT_PCT;
            end
            default: begin
                send_idle_pct = 0;
                pop_stall_pct = 0;
            end
        endcase
        // With the result side held off, back-to-back words fill the block queue.
        if (long_hold) begin
            hold_seq++;
        end
        run_blocks(n_items);
    endtask

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under reset coefficients.
        send_word(16'sd0, 16'sd0, 1'b1);           // silent block: no detail, no magnitude
        send_word(16'sd0, 16'sd1000, 1'b1);
        send_word(16'sd0, 16'sd0, 1'b1);           // detail with zero magnitude
        send_word(16'sh7FFF, 16'sh8000, 1'b0);     // most negative sample is full scale
        send_word(16'sh8000, 16'sh7FFF, 1'b0);
        send_word(16'sh8000, 16'sh8000, 1'b1);
        send_word(-16'sd1, 16'sd1, 1'b0);
        send_word(16'sd1, -16'sd1, 1'b0);
        send_word(16'sh5555, 16'shAAAA, 1'b0);
        send_word(16'shAAAA, 16'sh5555, 1'b1);
        send_word(16'sd0, 16'sd0, 1'b0);
        send_word(16'sd0, 16'sd0, 1'b0);
        for (k = 0; k < 4; k++) begin
            send_word(16'sh7FFF, 16'sh7FFF, 1'b0); // sharp onset for the transient peak
        end
        send_word(16'sd0, 16'sd0, 1'b1);
        send_word(16'sd100, -16'sd100, 1'b1);      // one-word blocks back to back
        send_word(16'sd200, -16'sd200, 1'b1);
        send_word(-16'sd300, 16'sd300, 1'b1);
        send_word(16'sh8000, 16'sh0000, 1'b1);

        run_phase(SET_RANDOM, PACE_SENDER_IDLE, PHASE_ITEMS, 1'b0);
        run_phase(SET_MAX, PACE_RECEIVER_STALL, PHASE_ITEMS, 1'b0);
        run_phase(SET_ZERO, PACE_BOTH, PHASE_ITEMS, 1'b0);
        run_phase(SET_GENTLE, PACE_STEADY, PHASE_ITEMS, 1'b1);
        run_phase(SET_SKEWED, PACE_SENDER_IDLE, PHASE_ITEMS, 1'b0);
        run_phase(SET_RANDOM, PACE_RECEIVER_STALL, PHASE_ITEMS, 1'b0);
        run_phase(SET_RESET, PACE_BOTH, PHASE_ITEMS, 1'b0);
        run_phase(SET_GENTLE, PACE_STEADY, PHASE_ITEMS, 1'b0);

        // One long block of full-scale swings drives both sums far up.
        // It runs at the steady pace left by the previous phase.
        wait_until_idle();
        write_coeffs(make_coeffs(SET_RESET));
        for (k = 0; k < LONG_BLOCK_LEN; k++) begin
            send_word(16'($urandom()), (k % 2) ? 16'sh8000 : 16'sh7FFF,
                      k == LONG_BLOCK_LEN - 1);
        end

        wait_until_idle();
        if (mismatches == 0) begin
            $display("dual_envelope_transient_tracker_unit regression: pass");
        end else begin
            $display("dual_envelope_transient_tracker_unit regression: fail");
        end
        $finish;
    end

endmodule
